@@ rtl/core/h264rtp_pkg.sv @@
// ----------------------------------------------------------------------------
// h264rtp_pkg
// Shared types and constants of the H.264 RTP FU-A packetizer.
// ----------------------------------------------------------------------------
package h264rtp_pkg;

    localparam int NalLenW   = 21;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 32;
    localparam int QueueDepth = 2;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_MAX_PACKET   = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_PAYLOAD_TYPE = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_SSRC         = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_FIRST_SEQ    = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_CHANNEL      = 3'd4;

    // register reset values
    localparam logic [15:0] RstMaxPacket  = 16'd1400;
    localparam logic [6:0]  RstPayloadType = 7'd96;
    localparam logic [31:0] RstSsrc       = 32'd0;
    localparam logic [15:0] RstFirstSeq   = 16'd0;
    localparam logic [7:0]  RstChannel    = 8'd0;

    localparam logic [15:0] MinPacket     = 16'd64;
    localparam logic [15:0] RtpHdrBytes   = 16'd12;
    localparam logic [15:0] FuPktHdrBytes = 16'd14;

    localparam logic [4:0]  NalTypeAud    = 5'd9;
    localparam logic [4:0]  NalTypeFuA    = 5'd28;
    localparam logic [7:0]  DollarByte    = 8'h24;
    localparam logic [7:0]  RtpVersionByte = 8'h80;

    // output sequencer steps, one per emitted byte
    localparam int StepW = 5;
    localparam logic [StepW-1:0] STEP_DOLLAR  = 5'd0;
    localparam logic [StepW-1:0] STEP_CHANNEL = 5'd1;
    localparam logic [StepW-1:0] STEP_LEN_HI  = 5'd2;
    localparam logic [StepW-1:0] STEP_LEN_LO  = 5'd3;
    localparam logic [StepW-1:0] STEP_VERSION = 5'd4;
    localparam logic [StepW-1:0] STEP_MPT     = 5'd5;
    localparam logic [StepW-1:0] STEP_SEQ_HI  = 5'd6;
    localparam logic [StepW-1:0] STEP_SEQ_LO  = 5'd7;
    localparam logic [StepW-1:0] STEP_TS_3    = 5'd8;
    localparam logic [StepW-1:0] STEP_TS_2    = 5'd9;
    localparam logic [StepW-1:0] STEP_TS_1    = 5'd10;
    localparam logic [StepW-1:0] STEP_TS_0    = 5'd11;
    localparam logic [StepW-1:0] STEP_SSRC_3  = 5'd12;
    localparam logic [StepW-1:0] STEP_SSRC_2  = 5'd13;
    localparam logic [StepW-1:0] STEP_SSRC_1  = 5'd14;
    localparam logic [StepW-1:0] STEP_SSRC_0  = 5'd15;
    localparam logic [StepW-1:0] STEP_FU_IND  = 5'd16;
    localparam logic [StepW-1:0] STEP_FU_HDR  = 5'd17;
    localparam logic [StepW-1:0] STEP_DATA    = 5'd18;

    typedef struct packed {
        logic [15:0] max_packet;
        logic [6:0]  payload_type;
        logic [31:0] ssrc;
        logic [15:0] first_seq;
        logic [7:0]  channel;
    } cfg_t;

    // one classified item: optional packet header, optional FU bytes, data byte
    typedef struct packed {
        logic        hdr;
        logic        fu;
        logic [15:0] rtp_len;
        logic        marker;
        logic [15:0] seq;
        logic [31:0] rtp_time;
        logic [7:0]  fu_ind;
        logic [7:0]  fu_hdr;
        logic [7:0]  data;
        logic        pend;
    } cmd_t;

endpackage

@@ rtl/core/h264rtp_front.sv @@
// ----------------------------------------------------------------------------
// h264rtp_front
// Classifies NAL bytes and tracks NAL/fragment state; pushes one command per
// byte that produces output.
// ----------------------------------------------------------------------------
module h264rtp_front #(
    parameter int MAX_NAL_BYTES = 1048576
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  h264rtp_pkg::cfg_t     cfg,
    input  logic                  seq_load,
    input  logic                  accept,
    input  logic [7:0]            nal_byte,
    input  logic                  nal_start,
    input  logic [20:0]           nal_length,
    input  logic [31:0]           rtp_time,
    input  logic                  ends_frame,
    output logic                  push,
    output h264rtp_pkg::cmd_t     cmd
);

    localparam int LenW = h264rtp_pkg::NalLenW;

    logic [15:0]     seq_reg, seq_next;
    logic            frag_mode_reg, frag_mode_next;
    logic            drop_reg, drop_next;
    logic [LenW-1:0] nal_left_reg, nal_left_next;
    logic [15:0]     frag_left_reg, frag_left_next;
    logic [31:0]     time_reg, time_next;
    logic [1:0]      nri_reg, nri_next;
    logic [4:0]      type_reg, type_next;
    logic            frame_end_reg, frame_end_next;
    logic            first_frag_reg, first_frag_next;

    logic [15:0]     mtu, single_max, frag_cap, flen, frag_cur, frag_dec;
    logic [LenW-1:0] len_nz, len_c, start_left, left_dec;
    logic            fits_single, frag_last;

    assign mtu        = (cfg.max_packet < h264rtp_pkg::MinPacket) ?
                        h264rtp_pkg::MinPacket : cfg.max_packet;
    assign single_max = mtu - h264rtp_pkg::RtpHdrBytes;
    assign frag_cap   = mtu - h264rtp_pkg::FuPktHdrBytes;

    assign len_nz     = (nal_length == '0) ? LenW'(1) : nal_length;
    assign len_c      = (32'(len_nz) > 32'(MAX_NAL_BYTES)) ? LenW'(MAX_NAL_BYTES) : len_nz;
    assign start_left = len_c - LenW'(1);
    assign fits_single = (len_c <= LenW'(single_max));

    assign left_dec   = nal_left_reg - LenW'(1);
    assign flen       = (nal_left_reg < LenW'(frag_cap)) ? nal_left_reg[15:0] : frag_cap;
    assign frag_last  = (LenW'(flen) == nal_left_reg);
    assign frag_cur   = (frag_left_reg == '0) ? flen : frag_left_reg;
    assign frag_dec   = frag_cur - 16'd1;

    always_comb begin
        seq_next        = seq_reg;
        frag_mode_next  = frag_mode_reg;
        drop_next       = drop_reg;
        nal_left_next   = nal_left_reg;
        frag_left_next  = frag_left_reg;
        time_next       = time_reg;
        nri_next        = nri_reg;
        type_next       = type_reg;
        frame_end_next  = frame_end_reg;
        first_frag_next = first_frag_reg;

        push         = 1'b0;
        cmd          = '0;
        cmd.data     = nal_byte;
        cmd.seq      = seq_reg;
        cmd.rtp_time = time_reg;
        cmd.fu_ind   = {1'b0, nri_reg, h264rtp_pkg::NalTypeFuA};

        if (accept) begin
            if (nal_start) begin
                // latch NAL header, abandon anything still open
                time_next       = rtp_time;
                frame_end_next  = ends_frame;
                nri_next        = nal_byte[6:5];
                type_next       = nal_byte[4:0];
                nal_left_next   = start_left;
                frag_left_next  = '0;
                first_frag_next = 1'b1;
                frag_mode_next  = 1'b0;
                drop_next       = 1'b0;
                if (nal_byte[4:0] == h264rtp_pkg::NalTypeAud) begin
                    drop_next = (start_left != '0);
                end else if (fits_single) begin
                    push         = 1'b1;
                    cmd.hdr      = 1'b1;
                    cmd.rtp_len  = len_c[15:0] + h264rtp_pkg::RtpHdrBytes;
                    cmd.marker   = ends_frame;
                    cmd.rtp_time = rtp_time;
                    cmd.pend     = (start_left == '0);
                    seq_next     = seq_reg + 16'd1;
                end else begin
                    frag_mode_next = 1'b1;
                end
            end else if (nal_left_reg != '0) begin
                nal_left_next = left_dec;
                if (drop_reg) begin
                    if (left_dec == '0) begin
                        drop_next = 1'b0;
                    end
                end else if (!frag_mode_reg) begin
                    push     = 1'b1;
                    cmd.pend = (left_dec == '0);
                end else begin
                    push           = 1'b1;
                    frag_left_next = frag_dec;
                    cmd.pend       = (frag_dec == '0);
                    if (frag_left_reg == '0) begin
                        // open a new fragment
                        cmd.hdr         = 1'b1;
                        cmd.fu          = 1'b1;
                        cmd.rtp_len     = flen + h264rtp_pkg::FuPktHdrBytes;
                        cmd.marker      = frag_last && frame_end_reg;
                        cmd.fu_hdr      = {first_frag_reg, frag_last, 1'b0, type_reg};
                        first_frag_next = 1'b0;
                        seq_next        = seq_reg + 16'd1;
                    end
                end
            end
        end

        if (seq_load) begin
            seq_next = cfg.first_seq;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg        <= h264rtp_pkg::RstFirstSeq;
            frag_mode_reg  <= 1'b0;
            drop_reg       <= 1'b0;
            nal_left_reg   <= '0;
            frag_left_reg  <= '0;
            time_reg       <= '0;
            nri_reg        <= '0;
            type_reg       <= '0;
            frame_end_reg  <= 1'b0;
            first_frag_reg <= 1'b1;
        end else begin
            seq_reg        <= seq_next;
            frag_mode_reg  <= frag_mode_next;
            drop_reg       <= drop_next;
            nal_left_reg   <= nal_left_next;
            frag_left_reg  <= frag_left_next;
            time_reg       <= time_next;
            nri_reg        <= nri_next;
            type_reg       <= type_next;
            frame_end_reg  <= frame_end_next;
            first_frag_reg <= first_frag_next;
        end
    end

endmodule

@@ rtl/core/h264rtp_cmdq.sv @@
// ----------------------------------------------------------------------------
// h264rtp_cmdq
// Short command queue between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
module h264rtp_cmdq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  h264rtp_pkg::cmd_t wdata,
    input  logic              pop,
    output h264rtp_pkg::cmd_t rdata,
    output logic              full,
    output logic              empty
);

    localparam int Depth = h264rtp_pkg::QueueDepth;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    h264rtp_pkg::cmd_t mem [Depth];
    logic [PtrW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0]   count_reg;
    logic              do_push, do_pop;

    assign full    = (count_reg == CntW'(Depth));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
            end
            count_reg <= count_reg + CntW'(do_push) - CntW'(do_pop);
        end
    end

endmodule

@@ rtl/core/h264rtp_back.sv @@
// ----------------------------------------------------------------------------
// h264rtp_back
// Byte sequencer: expands the head command into header, FU and data bytes
// into a registered output stage.
// ----------------------------------------------------------------------------
module h264rtp_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  h264rtp_pkg::cfg_t cfg,
    input  h264rtp_pkg::cmd_t head,
    input  logic              empty,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast,
    output logic              m_tuser
);

    localparam int StepW = h264rtp_pkg::StepW;

    logic [StepW-1:0] step_reg, step_next, cur_step, adv_step;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg, out_user_reg;
    logic             load, emit, done;
    logic [7:0]       byte_sel;

    // a command without header starts straight at its data byte
    assign cur_step = (step_reg == h264rtp_pkg::STEP_DOLLAR && !head.hdr) ?
                      h264rtp_pkg::STEP_DATA : step_reg;
    assign done     = (cur_step == h264rtp_pkg::STEP_DATA);
    assign load     = !out_valid_reg || m_tready;
    assign emit     = load && !empty;
    assign pop      = emit && done;

    always_comb begin
        if (cur_step == h264rtp_pkg::STEP_SSRC_0) begin
            adv_step = head.fu ? h264rtp_pkg::STEP_FU_IND : h264rtp_pkg::STEP_DATA;
        end else begin
            adv_step = cur_step + StepW'(1);
        end
        step_next = step_reg;
        if (emit) begin
            step_next = done ? h264rtp_pkg::STEP_DOLLAR : adv_step;
        end
    end

    always_comb begin
        unique case (cur_step)
            h264rtp_pkg::STEP_DOLLAR:  byte_sel = h264rtp_pkg::DollarByte;
            h264rtp_pkg::STEP_CHANNEL: byte_sel = cfg.channel;
            h264rtp_pkg::STEP_LEN_HI:  byte_sel = head.rtp_len[15:8];
            h264rtp_pkg::STEP_LEN_LO:  byte_sel = head.rtp_len[7:0];
            h264rtp_pkg::STEP_VERSION: byte_sel = h264rtp_pkg::RtpVersionByte;
            h264rtp_pkg::STEP_MPT:     byte_sel = {head.marker, cfg.payload_type};
            h264rtp_pkg::STEP_SEQ_HI:  byte_sel = head.seq[15:8];
            h264rtp_pkg::STEP_SEQ_LO:  byte_sel = head.seq[7:0];
            h264rtp_pkg::STEP_TS_3:    byte_sel = head.rtp_time[31:24];
            h264rtp_pkg::STEP_TS_2:    byte_sel = head.rtp_time[23:16];
            h264rtp_pkg::STEP_TS_1:    byte_sel = head.rtp_time[15:8];
            h264rtp_pkg::STEP_TS_0:    byte_sel = head.rtp_time[7:0];
            h264rtp_pkg::STEP_SSRC_3:  byte_sel = cfg.ssrc[31:24];
            h264rtp_pkg::STEP_SSRC_2:  byte_sel = cfg.ssrc[23:16];
            h264rtp_pkg::STEP_SSRC_1:  byte_sel = cfg.ssrc[15:8];
            h264rtp_pkg::STEP_SSRC_0:  byte_sel = cfg.ssrc[7:0];
            h264rtp_pkg::STEP_FU_IND:  byte_sel = head.fu_ind;
            h264rtp_pkg::STEP_FU_HDR:  byte_sel = head.fu_hdr;
            default:                   byte_sel = head.data;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= h264rtp_pkg::STEP_DOLLAR;
            out_valid_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            if (load) begin
                out_valid_reg <= !empty;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_byte_reg <= byte_sel;
            out_last_reg <= done && head.pend;
            out_user_reg <= done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule

@@ rtl/core/h264_rtp_fua_packetizer.sv @@
// ----------------------------------------------------------------------------
// h264_rtp_fua_packetizer
// H.264 NAL byte stream to RTP-over-TCP interleaved packets (single NAL and
// FU-A), one byte per cycle on each side when not held by back-pressure.
// ----------------------------------------------------------------------------
// Path: an accepted payload byte is written into the command queue and, with
//   nothing queued ahead of it, then loaded into the output register on m_tdata.
// Throughput: one payload byte per cycle while m_tready stays high; a packet start adds
//   16 header bytes (18 for an FU-A fragment), set by the one-byte-per-cycle output sequencer.
// Reset: synchronous on aresetn low; empties the command queue and output
//   stage, restores register defaults and reloads the sequence counter.
// ----------------------------------------------------------------------------
module h264_rtp_fua_packetizer #(
    parameter int MAX_NAL_BYTES = 1048576
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // nal_byte[7:0], nal_length[28:8], rtp_time[60:29],
                                   // ends_frame[61], zero[63:62]
    input  logic        s_tuser,   // nal_start[0]
    // packet stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tlast,   // packet_end
    output logic        m_tuser,   // run_last[0]
    // configuration
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    // configuration registers
    logic [15:0] max_packet_reg;
    logic [6:0]  payload_type_reg;
    logic [31:0] ssrc_reg;
    logic [15:0] first_seq_reg;
    logic [7:0]  channel_reg;

    h264rtp_pkg::cfg_t cfg;
    h264rtp_pkg::cmd_t push_cmd, head_cmd;
    logic              accept, push, pop, q_full, q_empty, seq_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_packet_reg   <= h264rtp_pkg::RstMaxPacket;
            payload_type_reg <= h264rtp_pkg::RstPayloadType;
            ssrc_reg         <= h264rtp_pkg::RstSsrc;
            first_seq_reg    <= h264rtp_pkg::RstFirstSeq;
            channel_reg      <= h264rtp_pkg::RstChannel;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                h264rtp_pkg::CFG_MAX_PACKET:   max_packet_reg   <= cfg_wdata[15:0];
                h264rtp_pkg::CFG_PAYLOAD_TYPE: payload_type_reg <= cfg_wdata[6:0];
                h264rtp_pkg::CFG_SSRC:         ssrc_reg         <= cfg_wdata;
                h264rtp_pkg::CFG_FIRST_SEQ:    first_seq_reg    <= cfg_wdata[15:0];
                h264rtp_pkg::CFG_CHANNEL:      channel_reg      <= cfg_wdata[7:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // the sequence counter reloads on the same edge as its register
    assign seq_load = cfg_wr_en && (cfg_addr == h264rtp_pkg::CFG_FIRST_SEQ);

    always_comb begin
        cfg.max_packet   = max_packet_reg;
        cfg.payload_type = payload_type_reg;
        cfg.ssrc         = ssrc_reg;
        cfg.first_seq    = seq_load ? cfg_wdata[15:0] : first_seq_reg;
        cfg.channel      = channel_reg;
    end

    // accept whenever the queue has room; every item makes at most one command
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    h264rtp_front #(
        .MAX_NAL_BYTES (MAX_NAL_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .seq_load   (seq_load),
        .accept     (accept),
        .nal_byte   (s_tdata[7:0]),
        .nal_start  (s_tuser),
        .nal_length (s_tdata[28:8]),
        .rtp_time   (s_tdata[60:29]),
        .ends_frame (s_tdata[61]),
        .push       (push),
        .cmd        (push_cmd)
    );

    h264rtp_cmdq u_cmdq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wdata   (push_cmd),
        .pop     (pop),
        .rdata   (head_cmd),
        .full    (q_full),
        .empty   (q_empty)
    );

    h264rtp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .head     (head_cmd),
        .empty    (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

@@ rtl/core/h264rtp_checker.sv @@
// ----------------------------------------------------------------------------
// h264rtp_checker
// Port-level checks of the packetizer, bound to the top level.
// ----------------------------------------------------------------------------
module h264rtp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    // reset empties the output stage
    a_reset_out_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high right after reset");

    // reset empties the queue, so input is ready next cycle
    a_reset_in_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("s_tready low right after reset");

    // a packet always ends on the data byte, which closes its item
    a_end_closes_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser)
        else $error("packet end without run_last");

    // stalled output holds its byte and flags
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
        else $error("output changed while stalled");

endmodule

bind h264_rtp_fua_packetizer h264rtp_checker u_checker (.*);

@@ verif/tb_h264_rtp_fua_packetizer.sv @@
// ----------------------------------------------------------------------------
// tb_h264_rtp_fua_packetizer
// Self-checking bench for the H.264 RTP FU-A packetizer: streams NAL bytes,
// predicts the interleaved packet bytes and compares each output item.
// ----------------------------------------------------------------------------
module tb_h264_rtp_fua_packetizer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         MaxNalBytes = 1048576;
    localparam int         IdlePct     = 37;
    localparam int         RxHoldLen   = 300;
    localparam logic [7:0] MarkerFlag  = 8'h80;
    localparam logic [7:0] FuStartFlag = 8'h80;
    localparam logic [7:0] FuEndFlag   = 8'h40;

    // one NAL byte as offered on the input stream
    typedef struct packed {
        logic [7:0]  nal_byte;
        logic        nal_start;
        logic [20:0] nal_length;
        logic [31:0] rtp_time;
        logic        ends_frame;
    } nal_item_t;

    // one byte of the interleaved packet stream
    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_end;
        logic       run_last;
    } wire_byte_t;

    logic                             aclk;
    logic                             aresetn   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [63:0]                      s_tdata   = '0;   // nal_byte, nal_length, rtp_time,
                                                        // ends_frame
    logic                             s_tuser   = 1'b0; // nal_start
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [7:0]                       m_tdata;          // out_byte
    logic                             m_tlast;          // packet_end
    logic                             m_tuser;          // run_last
    logic                             cfg_wr_en = 1'b0;
    logic [h264rtp_pkg::CfgIdxW-1:0]  cfg_addr  = '0;
    logic [h264rtp_pkg::CfgDataW-1:0] cfg_wdata = '0;

    // input items waiting to be driven, packet bytes waiting to be seen
    nal_item_t  nal_q[$];
    wire_byte_t packet_q[$];
    nal_item_t  cur_item;

    int  errors       = 0;
    bit  no_idle      = 1'b0;  // drop random gaps on both sides
    bit  rx_hold_req  = 1'b0;  // ask the receiver for one long hold-off
    bit  rx_hold_done = 1'b0;
    int  rx_hold_left = 0;

    // register copies as the block should hold them
    logic [15:0] reg_max_packet   = h264rtp_pkg::RstMaxPacket;
    logic [6:0]  reg_payload_type = h264rtp_pkg::RstPayloadType;
    logic [31:0] reg_ssrc         = h264rtp_pkg::RstSsrc;
    logic [7:0]  reg_channel      = h264rtp_pkg::RstChannel;

    // packetizer state
    logic [15:0] seq_no     = h264rtp_pkg::RstFirstSeq;
    bit          in_fu      = 1'b0;
    bit          skip_nal   = 1'b0;
    int unsigned nal_left   = 0;
    int unsigned frag_left  = 0;
    logic [31:0] nal_time   = '0;
    logic [1:0]  nal_nri    = '0;
    logic [4:0]  nal_type   = '0;
    bit          nal_ends   = 1'b0;
    bit          fu_first   = 1'b1;

    h264_rtp_fua_packetizer #(
        .MAX_NAL_BYTES(MaxNalBytes)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic void push_wire_byte(logic [7:0] b, logic pend);
        wire_byte_t wb;
        wb = '{out_byte: b, packet_end: pend, run_last: 1'b0};
        packet_q.insert(packet_q.size(), wb);
    endfunction

    // '$', channel, RTP length, then the 12-byte RTP header; bump the sequence
    function automatic void push_rtp_header(int unsigned rtp_len, logic marker);
        logic [15:0] plen;
        plen = rtp_len[15:0];
        push_wire_byte(h264rtp_pkg::DollarByte, 1'b0);
        push_wire_byte(reg_channel, 1'b0);
        push_wire_byte(plen[15:8], 1'b0);
        push_wire_byte(plen[7:0], 1'b0);
        push_wire_byte(h264rtp_pkg::RtpVersionByte, 1'b0);
        push_wire_byte((marker ? MarkerFlag : 8'h00) | {1'b0, reg_payload_type}, 1'b0);
        push_wire_byte(seq_no[15:8], 1'b0);
        push_wire_byte(seq_no[7:0], 1'b0);
        push_wire_byte(nal_time[31:24], 1'b0);
        push_wire_byte(nal_time[23:16], 1'b0);
        push_wire_byte(nal_time[15:8], 1'b0);
        push_wire_byte(nal_time[7:0], 1'b0);
        push_wire_byte(reg_ssrc[31:24], 1'b0);
        push_wire_byte(reg_ssrc[23:16], 1'b0);
        push_wire_byte(reg_ssrc[15:8], 1'b0);
        push_wire_byte(reg_ssrc[7:0], 1'b0);
        seq_no = seq_no + 16'd1;
    endfunction

    // advance the packetizer by one accepted NAL byte
    function automatic void packetize(nal_item_t it);
        int unsigned mtu;
        int unsigned len;
        int unsigned frag_cap;
        int unsigned flen;
        int          first_new;
        bit          fu_last;
        first_new = packet_q.size();
        mtu = (reg_max_packet < h264rtp_pkg::MinPacket) ?
              h264rtp_pkg::MinPacket : reg_max_packet;
        if (it.nal_start) begin
            len = it.nal_length;
            if (len == 0) len = 1;
            if (len > MaxNalBytes) len = MaxNalBytes;
            nal_time  = it.rtp_time;
            nal_ends  = it.ends_frame;
            nal_nri   = it.nal_byte[6:5];
            nal_type  = it.nal_byte[4:0];
            nal_left  = len - 1;
            frag_left = 0;
            fu_first  = 1'b1;
            in_fu     = 1'b0;
            skip_nal  = 1'b0;
            if (nal_type == h264rtp_pkg::NalTypeAud) begin
                skip_nal = (nal_left != 0);
            end else if (len <= mtu - h264rtp_pkg::RtpHdrBytes) begin
                push_rtp_header(h264rtp_pkg::RtpHdrBytes + len, nal_ends);
                push_wire_byte(it.nal_byte, nal_left == 0);
            end else begin
                // header byte is folded into the FU indicator and FU header
                in_fu = 1'b1;
            end
        end else if (nal_left != 0) begin
            if (skip_nal) begin
                nal_left--;
                if (nal_left == 0) skip_nal = 1'b0;
            end else if (!in_fu) begin
                nal_left--;
                push_wire_byte(it.nal_byte, nal_left == 0);
            end else begin
                if (frag_left == 0) begin
                    frag_cap = mtu - h264rtp_pkg::FuPktHdrBytes;
                    flen     = (nal_left < frag_cap) ? nal_left : frag_cap;
                    fu_last  = (flen == nal_left);
                    push_rtp_header(h264rtp_pkg::FuPktHdrBytes + flen, fu_last && nal_ends);
                    push_wire_byte({1'b0, nal_nri, h264rtp_pkg::NalTypeFuA}, 1'b0);
                    push_wire_byte((fu_first ? FuStartFlag : 8'h00) |
                                   (fu_last ? FuEndFlag : 8'h00) |
                                   {3'b000, nal_type}, 1'b0);
                    fu_first  = 1'b0;
                    frag_left = flen;
                end
                frag_left--;
                nal_left--;
                push_wire_byte(it.nal_byte, frag_left == 0);
            end
        end
        if (packet_q.size() > first_new) packet_q[packet_q.size() - 1].run_last = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Input driver: offer queued NAL bytes, predict on every accepted item
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) packetize(cur_item);
            // hold the current item until taken, then load the next or idle
            if (!s_tvalid || s_tready) begin
                if (nal_q.size() != 0 && (no_idle || $urandom_range(99) >= IdlePct)) begin
                    cur_item = nal_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {2'b00, cur_item.ends_frame, cur_item.rtp_time,
                                 cur_item.nal_length, cur_item.nal_byte};
                    s_tuser  <= cur_item.nal_start;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor: compare each accepted item with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        wire_byte_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (packet_q.size() == 0) begin
                    $error("unexpected output item: out_byte %02h", m_tdata);
                    errors++;
                end else begin
                    want = packet_q.pop_front();
                    if (m_tdata !== want.out_byte) begin
                        $error("out_byte: expected %02h, got %02h", want.out_byte, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== want.packet_end) begin
                        $error("packet_end: expected %0b, got %0b", want.packet_end, m_tlast);
                        errors++;
                    end
                    if (m_tuser !== want.run_last) begin
                        $error("run_last: expected %0b, got %0b", want.run_last, m_tuser);
                        errors++;
                    end
                end
            end
            // one long hold-off on request so the block backs up into its input
            if (rx_hold_req && !rx_hold_done) begin
                rx_hold_left = RxHoldLen;
                rx_hold_done = 1'b1;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= no_idle || ($urandom_range(99) >= IdlePct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // header byte with a random NRI and forbidden bit; access unit delimiters
    // show up often enough to exercise the drop path
    function automatic logic [7:0] rand_nal_header();
        logic [4:0] kind;
        kind = ($urandom_range(99) < 15) ? h264rtp_pkg::NalTypeAud : 5'($urandom_range(0, 31));
        return {3'($urandom_range(0, 7)), kind};
    endfunction

    // queue 'count' non-start bytes with random content in every field
    task automatic queue_body_bytes(int count);
        nal_item_t it;
        for (int i = 0; i < count; i++) begin
            it.nal_byte   = 8'($urandom);
            it.nal_start  = 1'b0;
            it.nal_length = 21'($urandom);
            it.rtp_time   = $urandom;
            it.ends_frame = 1'($urandom);
            nal_q.insert(nal_q.size(), it);
        end
    endtask

    // queue a NAL header item and 'sent'-1 body bytes; sent below the declared
    // length leaves the NAL open for the next start to cut off
    task automatic queue_nal(logic [7:0] hdr, logic [20:0] declared, int sent,
                             logic [31:0] stamp, logic ends);
        nal_item_t it;
        it.nal_byte   = hdr;
        it.nal_start  = 1'b1;
        it.nal_length = declared;
        it.rtp_time   = stamp;
        it.ends_frame = ends;
        nal_q.insert(nal_q.size(), it);
        queue_body_bytes(sent - 1);
    endtask

    // mostly whole NALs, some cut short with wild lengths, some loose bytes
    task automatic queue_random(int budget, int max_len);
        int done;
        int pick;
        int len;
        done = 0;
        while (done < budget) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                len = $urandom_range(1, max_len);
                queue_nal(rand_nal_header(), 21'(len), len, $urandom, 1'($urandom));
                done += len;
            end else if (pick < 92) begin
                len = $urandom_range(1, 6);
                queue_nal(rand_nal_header(), 21'($urandom), len, $urandom, 1'($urandom));
                done += len;
            end else begin
                queue_body_bytes($urandom_range(1, 3));
            end
        end
    endtask

    // pause until every item is taken and every packet byte seen, then let
    // items that produce nothing clear the pipeline
    task automatic wait_drained();
        do @(negedge aclk);
        while (!(nal_q.size() == 0 && !s_tvalid && packet_q.size() == 0));
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(logic [h264rtp_pkg::CfgIdxW-1:0] idx,
                             logic [h264rtp_pkg::CfgDataW-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            h264rtp_pkg::CFG_MAX_PACKET:   reg_max_packet   = val[15:0];
            h264rtp_pkg::CFG_PAYLOAD_TYPE: reg_payload_type = val[6:0];
            h264rtp_pkg::CFG_SSRC:         reg_ssrc         = val;
            h264rtp_pkg::CFG_FIRST_SEQ:    seq_no           = val[15:0];
            h264rtp_pkg::CFG_CHANNEL:      reg_channel      = val[7:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed, reset registers (1400-byte packets)
        queue_body_bytes(1);                                         // loose byte, no NAL open
        queue_nal(8'h65, 21'd1, 1, 32'h0000_0000, 1'b1);             // one-byte NAL, marker
        queue_nal(8'h00, 21'd0, 1, 32'hFFFF_FFFF, 1'b0);             // zero length acts as one
        queue_nal(8'h09, 21'd1, 1, $urandom, 1'b1);                  // bare delimiter
        queue_nal(8'h29, 21'd3, 3, $urandom, 1'b0);                  // delimiter with body
        queue_nal(8'hFF, 21'd4, 4, 32'h8000_0001, 1'b1);             // all-ones header
        queue_nal(8'h5C, 21'h1F_FFFF, 3, $urandom, 1'b1);            // saturated, cut short
        queue_nal(8'h41, 21'd1388, 2, $urandom, 1'b0);               // largest single, cut
        queue_nal(8'h41, 21'd1389, 1, $urandom, 1'b1);               // fragment start only
        queue_nal(8'h06, 21'd2, 2, $urandom, 1'b1);
        queue_body_bytes(1);                                         // loose byte after a NAL
        wait_drained();

        // extremes: packet size below the floor, sequence about to wrap
        write_reg(h264rtp_pkg::CFG_MAX_PACKET, 32'd20);
        write_reg(h264rtp_pkg::CFG_PAYLOAD_TYPE, 32'd127);
        write_reg(h264rtp_pkg::CFG_SSRC, 32'hFFFF_FFFF);
        write_reg(h264rtp_pkg::CFG_FIRST_SEQ, 32'h0000_FFFF);
        write_reg(h264rtp_pkg::CFG_CHANNEL, 32'd255);

        // a stretch with no gaps on either side
        no_idle = 1'b1;
        queue_random(25, 100);
        wait_drained();
        no_idle = 1'b0;

        // change the packet size in the middle of a fragmented NAL
        queue_nal({1'b0, 2'd3, 5'd5}, 21'd70, 26, $urandom, 1'b1);
        wait_drained();
        write_reg(h264rtp_pkg::CFG_MAX_PACKET, 32'd70);
        queue_body_bytes(44);
        wait_drained();

        // largest packets: whole NALs go out as single NAL units, wild lengths still fragment
        write_reg(h264rtp_pkg::CFG_PAYLOAD_TYPE, 32'd0);
        write_reg(h264rtp_pkg::CFG_SSRC, $urandom);
        write_reg(h264rtp_pkg::CFG_FIRST_SEQ, $urandom_range(0, 65535));
        write_reg(h264rtp_pkg::CFG_CHANNEL, 32'd0);
        write_reg(h264rtp_pkg::CFG_MAX_PACKET, 32'd65535);
        queue_random(15, 40);
        wait_drained();

        // smallest legal packets with the receiver stalled for a while
        write_reg(h264rtp_pkg::CFG_MAX_PACKET, 32'd64);
        write_reg(h264rtp_pkg::CFG_PAYLOAD_TYPE, $urandom_range(0, 127));
        write_reg(h264rtp_pkg::CFG_CHANNEL, $urandom_range(0, 255));
        rx_hold_req = 1'b1;
        queue_random(15, 100);
        wait_drained();

        repeat (20) @(negedge aclk);
        if (packet_q.size() != 0) begin
            $error("%0d predicted output items never arrived", packet_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // hard stop if the stream hangs
    initial begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
